[hw/rtl/imap_pkg.sv]
package imap_pkg;

	localparam int WORD_W     = 16;
	localparam int COUNT_W    = 5;
	localparam int INDEX_W    = 4;
	localparam int FRAC_W     = 16;
	localparam int DIV_CNT_W  = $clog2(FRAC_W);
	localparam int CFG_IDX_W  = 1;

	typedef enum logic [1:0] {
		OP_LOOKUP     = 2'd0,
		OP_SPEED_EDGE = 2'd1,
		OP_LOAD_EDGE  = 2'd2,
		OP_CELL       = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED_COUNT = 1'b0,
		REG_LOAD_COUNT  = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_CHK0,
		ST_CHKL,
		ST_SCAN,
		ST_DIV,
		ST_CELL0,
		ST_CELL1,
		ST_CELL2,
		ST_BLEND0,
		ST_CELL3,
		ST_BLEND1,
		ST_BLEND2,
		ST_DONE
	} state_t;

	typedef enum logic {
		ARITH_DIV,
		ARITH_BLEND
	} arith_op_t;

	typedef struct packed {
		arith_op_t         op;
		logic [WORD_W-1:0] opa;
		logic [WORD_W-1:0] opb;
		logic [FRAC_W-1:0] frac;
	} arith_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] res;
		logic              qbit;
	} arith_rsp_t;

	typedef struct packed {
		logic speed;
		logic load;
		logic map_cell;
	} wr_en_t;

endpackage

[hw/rtl/imap_if.sv]
interface imap_req_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          opcode;
	logic [imap_pkg::INDEX_W-1:0]        column_index;
	logic [imap_pkg::INDEX_W-1:0]        row_index;
	logic [imap_pkg::WORD_W-1:0]         write_word;
	logic [imap_pkg::WORD_W-1:0]         engine_speed;
	logic [imap_pkg::WORD_W-1:0]         engine_load;

	modport source (output valid, opcode, column_index, row_index, write_word,
		engine_speed, engine_load, input ready);
	modport sink (input valid, opcode, column_index, row_index, write_word,
		engine_speed, engine_load, output ready);
endinterface

interface imap_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [imap_pkg::WORD_W-1:0]  advance;
	logic                                map_absent;

	modport source (output valid, advance, map_absent, input ready);
	modport sink (input valid, advance, map_absent, output ready);
endinterface

interface imap_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [imap_pkg::CFG_IDX_W-1:0]      index;
	logic [imap_pkg::COUNT_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/imap_arith.sv]
module imap_arith (
	input  imap_pkg::arith_req_t req,
	output imap_pkg::arith_rsp_t rsp
);
	import imap_pkg::*;

	logic [WORD_W:0]          rem_x2;
	logic                     ge;
	logic signed [WORD_W:0]   diff;
	logic signed [FRAC_W:0]   frac_s;
	logic signed [33:0]       prod;
	logic signed [33:0]       sum;

	always_comb begin
		rem_x2 = {req.opa, 1'b0};
		ge     = rem_x2 >= {1'b0, req.opb};
		diff   = $signed({req.opb[WORD_W-1], req.opb}) - $signed({req.opa[WORD_W-1], req.opa});
		frac_s = $signed({1'b0, req.frac});
		prod   = diff * frac_s;
		sum    = $signed({{(34-WORD_W){req.opa[WORD_W-1]}}, req.opa}) + (prod >>> FRAC_W);
		unique case (req.op)
			ARITH_DIV: begin
				rsp.qbit = ge;
				rsp.res  = ge ? WORD_W'(rem_x2 - {1'b0, req.opb}) : rem_x2[WORD_W-1:0];
			end
			ARITH_BLEND: begin
				rsp.qbit = 1'b0;
				rsp.res  = sum[WORD_W-1:0];
			end
			default: begin
				rsp.qbit = 1'b0;
				rsp.res  = '0;
			end
		endcase
	end
endmodule

[hw/rtl/imap_store.sv]
module imap_store #(
	parameter int SPEED_BINS = 16,
	parameter int LOAD_BINS  = 16
) (
	input  logic                                            clk,
	input  imap_pkg::wr_en_t                                wr_en,
	input  logic [imap_pkg::INDEX_W-1:0]                    wr_col,
	input  logic [imap_pkg::INDEX_W-1:0]                    wr_row,
	input  logic [imap_pkg::WORD_W-1:0]                     wr_word,
	input  logic [$clog2(SPEED_BINS)-1:0]                   speed_raddr,
	input  logic [$clog2(LOAD_BINS)-1:0]                    load_raddr,
	input  logic [$clog2(SPEED_BINS*LOAD_BINS)-1:0]         cell_raddr,
	output logic [imap_pkg::WORD_W-1:0]                     speed_rdata,
	output logic [imap_pkg::WORD_W-1:0]                     load_rdata,
	output logic [imap_pkg::WORD_W-1:0]                     cell_rdata
);
	import imap_pkg::*;

	localparam int SW    = $clog2(SPEED_BINS);
	localparam int LW    = $clog2(LOAD_BINS);
	localparam int CELLS = SPEED_BINS * LOAD_BINS;
	localparam int CAW   = $clog2(CELLS);

	logic [WORD_W-1:0] speed_mem [SPEED_BINS];
	logic [WORD_W-1:0] load_mem  [LOAD_BINS];
	logic [WORD_W-1:0] cell_mem  [CELLS];

	logic              col_ok;
	logic              row_ok;
	logic [CAW-1:0]    cell_waddr;

	always_comb begin
		col_ok     = int'(wr_col) < SPEED_BINS;
		row_ok     = int'(wr_row) < LOAD_BINS;
		cell_waddr = CAW'(int'(wr_row) * SPEED_BINS + int'(wr_col));
	end

	always_ff @(posedge clk) begin
		if (wr_en.speed && col_ok) begin
			speed_mem[SW'(wr_col)] <= wr_word;
		end
		speed_rdata <= speed_mem[speed_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr_en.load && row_ok) begin
			load_mem[LW'(wr_row)] <= wr_word;
		end
		load_rdata <= load_mem[load_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr_en.map_cell && col_ok && row_ok) begin
			cell_mem[cell_waddr] <= wr_word;
		end
		cell_rdata <= cell_mem[cell_raddr];
	end
endmodule

[hw/rtl/ignition_map_bilinear_lookup_core.sv]
// Channel   Direction  Payload
// req       sink       opcode, column_index, row_index, write_word, engine_speed, engine_load
// rsp       source     advance, map_absent
// cfg       sink       index, data (bin counts)
//
// The edge scan reads one edge per cycle and the shared divider retires one fraction bit
// per cycle. Reset clears the counts and the sequencer; the stores hold no value until
// written. The result waits in an output register, so a stalled rsp only holds the block
// once a second lookup has finished.
module ignition_map_bilinear_lookup_core #(
	parameter int SPEED_BINS = 16,
	parameter int LOAD_BINS  = 16
) (
	input logic        clk,
	input logic        arst_n,
	imap_req_if.sink   req,
	imap_rsp_if.source rsp,
	imap_cfg_if.sink   cfg
);
	import imap_pkg::*;

	localparam int SW   = $clog2(SPEED_BINS);
	localparam int LW   = $clog2(LOAD_BINS);
	localparam int CAW  = $clog2(SPEED_BINS * LOAD_BINS);
	localparam int MAXB = (SPEED_BINS > LOAD_BINS) ? SPEED_BINS : LOAD_BINS;
	localparam int XW   = $clog2(MAXB + 1);

	state_t              state_q, state_d;
	logic [COUNT_W-1:0]  speed_cnt_q, load_cnt_q;
	logic [XW-1:0]       ns_eff, nl_eff;
	logic [XW-1:0]       n_q, nl_q, idx_q, lo_q, hi_q, rd_idx, n_last;
	logic [WORD_W-1:0]   v_q, ld_q, prev_q, rem_q, den_q, quot_q, edge_val;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                axis_q, absent_q;
	logic [SW-1:0]       xl_q, xh_q;
	logic [LW-1:0]       yl_q, yh_q;
	logic [FRAC_W-1:0]   xf_q, yf_q, fin_frac;
	logic [XW-1:0]       fin_lo, fin_hi;
	logic                fin, found, lookup_acc;
	logic [WORD_W-1:0]   a_q, b_q, v0_q;
	logic [SW-1:0]       cell_col;
	logic [LW-1:0]       cell_row;
	logic [CAW-1:0]      cell_raddr;
	logic [WORD_W-1:0]   speed_rdata, load_rdata, cell_rdata;
	logic                out_valid_q, out_absent_q, out_load;
	logic [WORD_W-1:0]   out_adv_q;
	wr_en_t              wr_en;
	arith_req_t          a_req;
	arith_rsp_t          a_rsp;

	imap_store #(.SPEED_BINS(SPEED_BINS), .LOAD_BINS(LOAD_BINS)) u_store (
		.clk         (clk),
		.wr_en       (wr_en),
		.wr_col      (req.column_index),
		.wr_row      (req.row_index),
		.wr_word     (req.write_word),
		.speed_raddr (rd_idx[SW-1:0]),
		.load_raddr  (rd_idx[LW-1:0]),
		.cell_raddr  (cell_raddr),
		.speed_rdata (speed_rdata),
		.load_rdata  (load_rdata),
		.cell_rdata  (cell_rdata)
	);

	imap_arith u_arith (
		.req (a_req),
		.rsp (a_rsp)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_cnt_q <= '0;
			load_cnt_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_SPEED_COUNT: speed_cnt_q <= cfg.data;
				REG_LOAD_COUNT:  load_cnt_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ns_eff     = (int'(speed_cnt_q) > SPEED_BINS) ? XW'(SPEED_BINS) : XW'(speed_cnt_q);
		nl_eff     = (int'(load_cnt_q) > LOAD_BINS) ? XW'(LOAD_BINS) : XW'(load_cnt_q);
		lookup_acc = req.valid && req.ready && (opcode_t'(req.opcode) == OP_LOOKUP);
		edge_val   = axis_q ? load_rdata : speed_rdata;
		n_last     = n_q - XW'(1);
		out_load   = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	end

	always_comb begin
		fin      = 1'b0;
		found    = 1'b0;
		fin_lo   = '0;
		fin_hi   = '0;
		fin_frac = '0;
		unique case (state_q)
			ST_CHK0: begin
				fin = (n_q == XW'(1)) || (v_q <= edge_val);
			end
			ST_CHKL: begin
				fin    = v_q >= edge_val;
				fin_lo = n_last;
				fin_hi = n_last;
			end
			ST_SCAN: begin
				found  = (v_q >= prev_q) && (v_q < edge_val);
				fin    = !found && (idx_q == n_last);
				fin_lo = n_last;
				fin_hi = n_last;
			end
			ST_DIV: begin
				fin      = cnt_q == DIV_CNT_W'(FRAC_W - 1);
				fin_lo   = lo_q;
				fin_hi   = hi_q;
				fin_frac = {quot_q[FRAC_W-2:0], a_rsp.qbit};
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (lookup_acc) begin
					state_d = (ns_eff == '0 || nl_eff == '0) ? ST_DONE : ST_RD0;
				end
			end
			ST_RD0:    state_d = ST_CHK0;
			ST_CHK0:   state_d = fin ? (axis_q ? ST_CELL0 : ST_RD0) : ST_CHKL;
			ST_CHKL:   state_d = fin ? (axis_q ? ST_CELL0 : ST_RD0) : ST_SCAN;
			ST_SCAN: begin
				if (found) begin
					state_d = ST_DIV;
				end else if (fin) begin
					state_d = axis_q ? ST_CELL0 : ST_RD0;
				end
			end
			ST_DIV: begin
				if (fin) begin
					state_d = axis_q ? ST_CELL0 : ST_RD0;
				end
			end
			ST_CELL0:  state_d = ST_CELL1;
			ST_CELL1:  state_d = ST_CELL2;
			ST_CELL2:  state_d = ST_BLEND0;
			ST_BLEND0: state_d = ST_CELL3;
			ST_CELL3:  state_d = ST_BLEND1;
			ST_BLEND1: state_d = ST_BLEND2;
			ST_BLEND2: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready      = state_q == ST_IDLE;
		wr_en.speed    = req.valid && req.ready && (opcode_t'(req.opcode) == OP_SPEED_EDGE);
		wr_en.load     = req.valid && req.ready && (opcode_t'(req.opcode) == OP_LOAD_EDGE);
		wr_en.map_cell = req.valid && req.ready && (opcode_t'(req.opcode) == OP_CELL);
		rd_idx      = '0;
		cell_col    = xl_q;
		cell_row    = yl_q;
		a_req.op    = ARITH_BLEND;
		a_req.opa   = a_q;
		a_req.opb   = b_q;
		a_req.frac  = xf_q;
		unique case (state_q)
			ST_CHK0:   rd_idx = n_last;
			ST_CHKL:   rd_idx = XW'(1);
			ST_SCAN:   rd_idx = idx_q + XW'(1);
			ST_DIV: begin
				a_req.op  = ARITH_DIV;
				a_req.opa = rem_q;
				a_req.opb = den_q;
			end
			ST_CELL1:  cell_col = xh_q;
			ST_CELL2:  cell_row = yh_q;
			ST_BLEND0: begin
				cell_col = xh_q;
				cell_row = yh_q;
			end
			ST_BLEND2: a_req.frac = yf_q;
			default: ;
		endcase
		cell_raddr = CAW'(int'(cell_row) * SPEED_BINS + int'(cell_col));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (lookup_acc) begin
			v_q      <= req.engine_speed;
			ld_q     <= req.engine_load;
			n_q      <= ns_eff;
			nl_q     <= nl_eff;
			axis_q   <= 1'b0;
			absent_q <= (ns_eff == '0) || (nl_eff == '0);
		end
		if (state_q == ST_CHK0 && !fin) begin
			prev_q <= edge_val;
		end
		if (state_q == ST_CHKL) begin
			idx_q <= XW'(1);
		end
		if (state_q == ST_SCAN) begin
			if (found) begin
				lo_q   <= idx_q - XW'(1);
				hi_q   <= idx_q;
				rem_q  <= v_q - prev_q;
				den_q  <= edge_val - prev_q;
				cnt_q  <= '0;
				quot_q <= '0;
			end else begin
				prev_q <= edge_val;
				idx_q  <= idx_q + XW'(1);
			end
		end
		if (state_q == ST_DIV) begin
			rem_q  <= a_rsp.res;
			quot_q <= {quot_q[FRAC_W-2:0], a_rsp.qbit};
			cnt_q  <= cnt_q + DIV_CNT_W'(1);
		end
		if (fin) begin
			if (axis_q) begin
				yl_q <= fin_lo[LW-1:0];
				yh_q <= fin_hi[LW-1:0];
				yf_q <= fin_frac;
			end else begin
				xl_q   <= fin_lo[SW-1:0];
				xh_q   <= fin_hi[SW-1:0];
				xf_q   <= fin_frac;
				axis_q <= 1'b1;
				v_q    <= ld_q;
				n_q    <= nl_q;
			end
		end
		unique case (state_q)
			ST_CELL1:  a_q <= cell_rdata;
			ST_CELL2:  b_q <= cell_rdata;
			ST_BLEND0: begin
				v0_q <= a_rsp.res;
				a_q  <= cell_rdata;
			end
			ST_CELL3:  b_q <= cell_rdata;
			ST_BLEND1: begin
				b_q <= a_rsp.res;
				a_q <= v0_q;
			end
			ST_BLEND2: v0_q <= a_rsp.res;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_adv_q    <= absent_q ? '0 : v0_q;
			out_absent_q <= absent_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.advance    = out_adv_q;
	assign rsp.map_absent = out_absent_q;

	a_div_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder reached the divisor");

	a_scan_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q != '0 && idx_q < n_q))
		else $error("edge scan index left the bins in use");

	a_absent_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_absent_q) |-> (out_adv_q == '0))
		else $error("absent map returned a nonzero advance");

	a_done_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished lookup was not presented");
endmodule

[bench/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import imap_pkg::*;

	localparam int BINS = 16;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 110;
	localparam int PRESSURE_PHASE = 4;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int QUIET_LIMIT = 5000;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_e;

	typedef struct {
		opcode_t     op;
		logic [3:0]  col;
		logic [3:0]  row;
		logic [15:0] word;
		logic [15:0] speed;
		logic [15:0] load;
	} map_req_t;

	typedef struct {
		logic signed [15:0] advance;
		logic               map_absent;
	} map_rsp_t;

	typedef struct {
		bit         is_cfg;
		cfg_reg_t   reg_sel;
		logic [4:0] count;
		map_req_t   item;
		bit         typed;
		map_rsp_t   want;
	} step_t;

	logic clk;
	logic arst_n;

	imap_req_if req_ch ();
	imap_rsp_if rsp_ch ();
	imap_cfg_if cfg_ch ();

	ignition_map_bilinear_lookup_core #(
		.SPEED_BINS(BINS),
		.LOAD_BINS(BINS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	logic [15:0]        edge_m [2][BINS];
	logic signed [15:0] cell_m [BINS*BINS];
	logic [4:0]         count_m [2];

	map_rsp_t   advance_due [$];
	map_req_t   pending_items [$];
	map_rsp_t   head;
	map_rsp_t   no_want;
	idle_mode_e idle_mode;
	bit         hold_req;
	int         hold_left;
	int         quiet;
	int         failures;
	int         lookups_sent;
	int         writes_sent;
	int         cfg_writes;
	int         results_checked;
	int         absent_results;

	logic [4:0] phase_speed [PHASES] = '{5'd16, 5'd31, 5'd2, 5'd1, 5'd16,
		5'd0, 5'd5, 5'd17, 5'd8, 5'd3};
	logic [4:0] phase_load [PHASES] = '{5'd16, 5'd17, 5'd3, 5'd16, 5'd1,
		5'd5, 5'd0, 5'd31, 5'd8, 5'd12};
	idle_mode_e phase_mode [PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
		IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_RECV};

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		failures++;
	endtask

	function automatic void bracket(input int axis, input logic [15:0] v, output int lo,
		output int hi, output longint frac);
		int n;
		longint a;
		longint b;
		lo = 0;
		hi = 0;
		frac = 0;
		n = (count_m[axis] > BINS) ? BINS : int'(count_m[axis]);
		if (n <= 1 || v <= edge_m[axis][0])
			return;
		if (v >= edge_m[axis][n-1]) begin
			lo = n - 1;
			hi = n - 1;
			return;
		end
		for (int i = 0; i + 1 < n; i++) begin
			a = longint'(edge_m[axis][i]);
			b = longint'(edge_m[axis][i+1]);
			if (longint'(v) >= a && longint'(v) < b) begin
				lo = i;
				hi = i + 1;
				frac = ((longint'(v) - a) << 16) / (b - a);
				return;
			end
		end
		lo = n - 1;
		hi = n - 1;
	endfunction

	// Floor rounding: the arithmetic shift of a signed product rounds toward minus infinity.
	function automatic longint blend(input longint a, input longint b, input longint frac);
		return a + (((b - a) * frac) >>> 16);
	endfunction

	function automatic bit predict_map_item(input map_req_t it, output map_rsp_t res);
		int xl;
		int xh;
		int yl;
		int yh;
		longint xf;
		longint yf;
		longint v0;
		longint v1;
		longint r;
		res.advance = 0;
		res.map_absent = 0;
		case (it.op)
			OP_SPEED_EDGE: begin
				edge_m[0][it.col] = it.word;
				return 0;
			end
			OP_LOAD_EDGE: begin
				edge_m[1][it.row] = it.word;
				return 0;
			end
			OP_CELL: begin
				cell_m[{it.row, it.col}] = it.word;
				return 0;
			end
			default: begin
			end
		endcase
		if (count_m[0] == 0 || count_m[1] == 0) begin
			res.map_absent = 1;
			return 1;
		end
		bracket(0, it.speed, xl, xh, xf);
		bracket(1, it.load, yl, yh, yf);
		v0 = blend(cell_m[yl*BINS+xl], cell_m[yl*BINS+xh], xf);
		v1 = blend(cell_m[yh*BINS+xl], cell_m[yh*BINS+xh], xf);
		r = blend(v0, v1, yf);
		res.advance = r[15:0];
		return 1;
	endfunction

	function automatic map_req_t noise_req();
		map_req_t it;
		it.op = opcode_t'($urandom_range(3));
		it.col = 4'($urandom());
		it.row = 4'($urandom());
		it.word = 16'($urandom());
		it.speed = 16'($urandom());
		it.load = 16'($urandom());
		return it;
	endfunction

	function automatic logic [15:0] cell_word();
		case ($urandom_range(11))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] pick_query(input int axis);
		int n;
		int i;
		int unsigned k;
		n = (count_m[axis] > BINS) ? BINS : int'(count_m[axis]);
		k = $urandom_range(99);
		if (k < 8)
			return 16'h0000;
		if (k < 16)
			return 16'hFFFF;
		if (n >= 1 && k < 36)
			return edge_m[axis][$urandom_range(n - 1)];
		if (n >= 2 && k < 85) begin
			i = $urandom_range(n - 2);
			return 16'($urandom_range(edge_m[axis][i+1], edge_m[axis][i]));
		end
		return 16'($urandom());
	endfunction

	function automatic step_t req_row(input opcode_t op, input logic [3:0] col,
		input logic [3:0] row, input logic [15:0] word, input logic [15:0] speed,
		input logic [15:0] load, input bit typed, input logic signed [15:0] adv,
		input bit absent);
		step_t s;
		s.is_cfg = 0;
		s.reg_sel = REG_SPEED_COUNT;
		s.count = 0;
		s.item.op = op;
		s.item.col = col;
		s.item.row = row;
		s.item.word = word;
		s.item.speed = speed;
		s.item.load = load;
		s.typed = typed;
		s.want.advance = adv;
		s.want.map_absent = absent;
		return s;
	endfunction

	function automatic step_t cfg_row(input cfg_reg_t sel, input logic [4:0] count);
		step_t s;
		s.is_cfg = 1;
		s.reg_sel = sel;
		s.count = count;
		s.item = noise_req();
		s.typed = 0;
		s.want.advance = 0;
		s.want.map_absent = 0;
		return s;
	endfunction

	function automatic void queue_edge_ramp(input int axis);
		map_req_t it;
		longint v;
		longint step_max;
		int style;
		style = $urandom_range(3);
		case (style)
			0: begin
				v = longint'($urandom_range(65535 - 64));
				step_max = 4;
			end
			1: begin
				v = 0;
				step_max = 4369;
			end
			2: begin
				v = 0;
				step_max = 0;
			end
			default: begin
				v = longint'($urandom_range(32767));
				step_max = (65535 - v) / 15;
			end
		endcase
		for (int i = 0; i < BINS; i++) begin
			if (style == 2 && i > 0)
				v = 65535;
			else if (i > 0 && $urandom_range(9) != 0)
				v = v + longint'($urandom_range(32'(step_max), 1));
			it = noise_req();
			it.op = (axis == 0) ? OP_SPEED_EDGE : OP_LOAD_EDGE;
			if (axis == 0)
				it.col = 4'(i);
			else
				it.row = 4'(i);
			it.word = v[15:0];
			pending_items.push_back(it);
		end
	endfunction

	function automatic void add_random_item();
		map_req_t it;
		int unsigned k;
		k = $urandom_range(99);
		it = noise_req();
		if (k < 62) begin
			it.op = OP_LOOKUP;
			it.speed = pick_query(0);
			it.load = pick_query(1);
		end else if (k < 64) begin
			queue_edge_ramp($urandom_range(1));
			return;
		end else if (k < 68) begin
			it.op = $urandom_range(1) ? OP_SPEED_EDGE : OP_LOAD_EDGE;
		end else begin
			it.op = OP_CELL;
			it.word = cell_word();
		end
		pending_items.push_back(it);
	endfunction

	function automatic bit takes_break(input bit sender);
		int unsigned pct;
		pct = 0;
		if (idle_mode == IDLE_BOTH)
			pct = 13;
		else if (sender && idle_mode == IDLE_SEND)
			pct = 66;
		else if (!sender && idle_mode == IDLE_RECV)
			pct = 66;
		return $urandom_range(99) < pct;
	endfunction

	task automatic send_item(input map_req_t it, input bit typed, input map_rsp_t want);
		map_rsp_t res;
		while (takes_break(1)) begin
			req_ch.valid = 0;
			@(negedge clk);
		end
		req_ch.valid = 1;
		req_ch.opcode = it.op;
		req_ch.column_index = it.col;
		req_ch.row_index = it.row;
		req_ch.write_word = it.word;
		req_ch.engine_speed = it.speed;
		req_ch.engine_load = it.load;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (predict_map_item(it, res)) begin
			advance_due.push_back(typed ? want : res);
			lookups_sent++;
		end else begin
			writes_sent++;
		end
		@(negedge clk);
	endtask

	task automatic settle();
		req_ch.valid = 0;
		while (advance_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_count(input cfg_reg_t sel, input logic [4:0] value);
		cfg_ch.valid = 1;
		cfg_ch.index = sel;
		cfg_ch.data = value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		count_m[sel] = value;
		cfg_writes++;
		@(negedge clk);
		cfg_ch.valid = 0;
	endtask

	task automatic drain_pending();
		while (pending_items.size() != 0)
			send_item(pending_items.pop_front(), 0, no_want);
	endtask

	initial begin
		rsp_ch.ready = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_ch.ready = 0;
				hold_left--;
			end else begin
				rsp_ch.ready = !takes_break(0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_checked++;
			if (rsp_ch.map_absent)
				absent_results++;
			if (advance_due.size() == 0) begin
				report_mismatch("unrequested result, advance", rsp_ch.advance, 0);
			end else begin
				head = advance_due.pop_front();
				if (rsp_ch.advance !== head.advance)
					report_mismatch("advance", rsp_ch.advance, head.advance);
				if (rsp_ch.map_absent !== head.map_absent)
					report_mismatch("map_absent", rsp_ch.map_absent, head.map_absent);
			end
		end
	end

	// The watchdog restarts on any transfer on any of the three channels.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", quiet);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		step_t      plan [$];
		logic [4:0] sc;
		logic [4:0] lc;
		int         issued;

		arst_n = 0;
		req_ch.valid = 0;
		req_ch.opcode = OP_LOOKUP;
		req_ch.column_index = 0;
		req_ch.row_index = 0;
		req_ch.write_word = 0;
		req_ch.engine_speed = 0;
		req_ch.engine_load = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = REG_SPEED_COUNT;
		cfg_ch.data = 0;
		idle_mode = IDLE_NONE;
		hold_req = 0;
		quiet = 0;
		failures = 0;
		lookups_sent = 0;
		writes_sent = 0;
		cfg_writes = 0;
		results_checked = 0;
		absent_results = 0;
		no_want.advance = 0;
		no_want.map_absent = 0;
		count_m[0] = 0;
		count_m[1] = 0;

		plan.push_back(req_row(OP_SPEED_EDGE, 4'd0, 4'd9, 16'd1000, 16'h0000, 16'hFFFF, 0, 0, 0));
		plan.push_back(req_row(OP_SPEED_EDGE, 4'd1, 4'd6, 16'd3000, 16'hFFFF, 16'h0000, 0, 0, 0));
		plan.push_back(req_row(OP_LOAD_EDGE, 4'd15, 4'd0, 16'h0000, 16'h5555, 16'hAAAA, 0, 0, 0));
		plan.push_back(req_row(OP_LOAD_EDGE, 4'd0, 4'd1, 16'hFFFF, 16'hAAAA, 16'h5555, 0, 0, 0));
		plan.push_back(req_row(OP_CELL, 4'd0, 4'd0, 16'h7FFF, 16'h0000, 16'h0000, 0, 0, 0));
		plan.push_back(req_row(OP_CELL, 4'd1, 4'd0, 16'h8000, 16'hFFFF, 16'hFFFF, 0, 0, 0));
		plan.push_back(req_row(OP_CELL, 4'd0, 4'd1, 16'h0000, 16'h1234, 16'h4321, 0, 0, 0));
		plan.push_back(req_row(OP_CELL, 4'd1, 4'd1, 16'hFFFF, 16'h4321, 16'h1234, 0, 0, 0));
		plan.push_back(req_row(OP_LOOKUP, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1, 16'sd0, 1));
		plan.push_back(cfg_row(REG_SPEED_COUNT, 5'd2));
		plan.push_back(req_row(OP_LOOKUP, 4'd5, 4'd10, 16'h0F0F, 16'd2000, 16'd100,
			1, 16'sd0, 1));
		plan.push_back(cfg_row(REG_LOAD_COUNT, 5'd2));
		plan.push_back(req_row(OP_LOOKUP, 4'd0, 4'd0, 16'h0000, 16'h0000, 16'h0000,
			1, 16'sh7FFF, 0));
		plan.push_back(req_row(OP_LOOKUP, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1, 16'shFFFF, 0));
		plan.push_back(req_row(OP_LOOKUP, 4'd3, 4'd12, 16'h00FF, 16'd1000, 16'h0000,
			1, 16'sh7FFF, 0));
		plan.push_back(req_row(OP_LOOKUP, 4'd12, 4'd3, 16'hFF00, 16'd3000, 16'h0000,
			1, 16'sh8000, 0));
		plan.push_back(req_row(OP_LOOKUP, 4'd0, 4'd0, 16'h0000, 16'd2000, 16'h0000, 0, 0, 0));
		plan.push_back(req_row(OP_LOOKUP, 4'd0, 4'd0, 16'h0000, 16'd2999, 16'd32768, 0, 0, 0));
		plan.push_back(req_row(OP_LOOKUP, 4'd0, 4'd0, 16'h0000, 16'd1001, 16'd65534, 0, 0, 0));
		plan.push_back(cfg_row(REG_SPEED_COUNT, 5'd1));
		plan.push_back(req_row(OP_LOOKUP, 4'd0, 4'd0, 16'h0000, 16'd2000, 16'd40000, 0, 0, 0));
		plan.push_back(cfg_row(REG_SPEED_COUNT, 5'd2));
		plan.push_back(req_row(OP_SPEED_EDGE, 4'd1, 4'd0, 16'd500, 16'h0000, 16'h0000, 0, 0, 0));
		plan.push_back(req_row(OP_LOOKUP, 4'd0, 4'd0, 16'h0000, 16'd800, 16'd20000, 0, 0, 0));
		plan.push_back(req_row(OP_LOOKUP, 4'd0, 4'd0, 16'h0000, 16'd2000, 16'd0, 0, 0, 0));

		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_count(plan[i].reg_sel, plan[i].count);
			end else begin
				send_item(plan[i].item, plan[i].typed, plan[i].want);
			end
		end

		// Every edge and cell gets a value before the random lookups can reach it.
		queue_edge_ramp(0);
		queue_edge_ramp(1);
		for (int k = 0; k < BINS * BINS; k++) begin
			pending_items.push_back(noise_req());
			pending_items[$].op = OP_CELL;
			pending_items[$].col = k[3:0];
			pending_items[$].row = k[7:4];
			pending_items[$].word = cell_word();
		end
		drain_pending();

		for (int p = 0; p < PHASES; p++) begin
			settle();
			sc = phase_speed[p];
			lc = phase_load[p];
			if (p >= PHASES - 2) begin
				sc = 5'($urandom_range(BINS, 1));
				lc = 5'($urandom_range(BINS, 1));
			end
			write_count(REG_SPEED_COUNT, sc);
			write_count(REG_LOAD_COUNT, lc);
			idle_mode = phase_mode[p];
			if (p == PRESSURE_PHASE) begin
				@(posedge clk);
				hold_req = 1;
				@(negedge clk);
			end
			issued = 0;
			while (issued < PHASE_ITEMS || pending_items.size() != 0) begin
				if (pending_items.size() == 0)
					add_random_item();
				send_item(pending_items.pop_front(), 0, no_want);
				issued++;
			end
		end

		settle();
		$display("Sent %0d lookups and %0d store writes under %0d bin-count writes.",
			lookups_sent, writes_sent, cfg_writes);
		$display("Checked %0d results, %0d of them with no map, %0d mismatches.",
			results_checked, absent_results, failures);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
